>>> sv/rhp_pkg.sv
// ----------------------------------------------------------------------------
// rhp_pkg
// shared types and constants of the rtp header parser
// ----------------------------------------------------------------------------
package rhp_pkg;

  localparam int unsigned LENGTH_BITS_DEF = 16;
  localparam int unsigned HDR_BYTES       = 12;
  localparam int unsigned OFFSET_W        = 19;
  localparam int unsigned APB_ADDR_W      = 3;
  localparam int unsigned APB_DATA_W      = 32;
  localparam int unsigned PT_W            = 7;
  localparam int unsigned RTP_VERSION     = 2;

  localparam logic [PT_W-1:0] PT_RESET = 7'd96;

  typedef enum logic [0:0] {
    REG_EXP_PT = 1'b0
  } reg_idx_e;

  typedef enum logic [3:0] {
    ST_OK         = 4'd0,
    ST_SHORT      = 4'd1,
    ST_VERSION    = 4'd2,
    ST_PT         = 4'd3,
    ST_CSRC_OVR   = 4'd4,
    ST_EXT_OVR    = 4'd5,
    ST_PADDING    = 4'd6,
    ST_EMPTY      = 4'd7,
    ST_TOO_LONG   = 4'd8
  } status_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_beat_t;

  typedef struct packed {
    status_e     status;
    logic        marker_bit;
    logic        padding_flag;
    logic        extension_flag;
    logic [3:0]  contributor_count;
    logic [15:0] sequence_number;
    logic [31:0] media_timestamp;
    logic [31:0] source_id;
    logic [15:0] payload_start;
    logic [15:0] payload_size;
  } out_beat_t;

  // header words of one packet, taken at its last byte
  typedef struct packed {
    logic [7:0]  first_hdr;
    logic [7:0]  second_hdr;
    logic [15:0] seq;
    logic [31:0] tstamp;
    logic [31:0] ssrc;
    logic [15:0] ext_wcnt;
    logic [7:0]  last_data;
  } snap_t;

endpackage

>>> sv/rhp_stream_if.sv
// ----------------------------------------------------------------------------
// rhp_stream_if
// valid/ready channel carrying one beat of a given type
// ----------------------------------------------------------------------------
interface rhp_stream_if #(
  parameter type beat_t = logic
);
  logic  valid;
  logic  ready;
  beat_t beat;

  modport source (output valid, output beat, input ready);
  modport sink   (input valid, input beat, output ready);
endinterface

>>> sv/rhp_check.sv
// ----------------------------------------------------------------------------
// rhp_check
// packet checks, payload offset and size from the captured header words
// ----------------------------------------------------------------------------
module rhp_check #(
  parameter int unsigned LengthBits = rhp_pkg::LENGTH_BITS_DEF
) (
  input  rhp_pkg::snap_t               snap_i,
  input  logic [LengthBits:0]          idx_i,
  input  logic [rhp_pkg::PT_W-1:0]     exp_pt_i,
  output rhp_pkg::out_beat_t           beat_o
);

  localparam int unsigned IdxW = LengthBits + 1;
  localparam int unsigned OffW = rhp_pkg::OFFSET_W;
  localparam logic [IdxW-1:0] MaxLen = IdxW'((1 << LengthBits) - 1);

  logic [IdxW-1:0] len;
  logic [OffW-1:0] len_x;
  logic [OffW-1:0] hdr_end;
  logic [OffW-1:0] ext_end;
  logic [OffW-1:0] offset;
  logic [OffW-1:0] remain;
  logic [OffW-1:0] remain_pad;
  logic [OffW-1:0] pad_cnt;
  logic            pad_on;
  logic            ext_on;
  rhp_pkg::status_e status;

  assign len     = idx_i + IdxW'(1);
  assign len_x   = OffW'(len);
  assign pad_on  = snap_i.first_hdr[5];
  assign ext_on  = snap_i.first_hdr[4];
  assign hdr_end = OffW'(rhp_pkg::HDR_BYTES) + OffW'({snap_i.first_hdr[3:0], 2'b00});
  assign ext_end = hdr_end + OffW'(4) + OffW'({snap_i.ext_wcnt, 2'b00});
  assign offset  = ext_on ? ext_end : hdr_end;
  assign remain  = len_x - offset;
  assign pad_cnt = OffW'(snap_i.last_data);
  assign remain_pad = pad_on ? (remain - pad_cnt) : remain;

  always_comb begin
    status = rhp_pkg::ST_OK;
    if (idx_i >= MaxLen) begin
      status = rhp_pkg::ST_TOO_LONG;
    end else if (len < IdxW'(rhp_pkg::HDR_BYTES)) begin
      status = rhp_pkg::ST_SHORT;
    end else if (snap_i.first_hdr[7:6] != 2'(rhp_pkg::RTP_VERSION)) begin
      status = rhp_pkg::ST_VERSION;
    end else if (snap_i.second_hdr[6:0] != exp_pt_i) begin
      status = rhp_pkg::ST_PT;
    end else if (hdr_end > len_x) begin
      status = rhp_pkg::ST_CSRC_OVR;
    end else if (ext_on && ((hdr_end + OffW'(4) > len_x) || (ext_end > len_x))) begin
      status = rhp_pkg::ST_EXT_OVR;
    end else if (pad_on && ((remain == '0) || (pad_cnt == '0) || (pad_cnt > remain))) begin
      status = rhp_pkg::ST_PADDING;
    end else if (remain_pad == '0) begin
      status = rhp_pkg::ST_EMPTY;
    end
  end

  always_comb begin
    beat_o.status            = status;
    beat_o.marker_bit        = snap_i.second_hdr[7];
    beat_o.padding_flag      = pad_on;
    beat_o.extension_flag    = ext_on;
    beat_o.contributor_count = snap_i.first_hdr[3:0];
    beat_o.sequence_number   = snap_i.seq;
    beat_o.media_timestamp   = snap_i.tstamp;
    beat_o.source_id         = snap_i.ssrc;
    beat_o.payload_start     = '0;
    beat_o.payload_size      = '0;
    if (status == rhp_pkg::ST_OK) begin
      beat_o.payload_start = 16'(offset);
      beat_o.payload_size  = 16'(remain_pad);
    end
    if (status == rhp_pkg::ST_SHORT) begin
      beat_o.marker_bit        = 1'b0;
      beat_o.padding_flag      = 1'b0;
      beat_o.extension_flag    = 1'b0;
      beat_o.contributor_count = '0;
      beat_o.sequence_number   = '0;
      beat_o.media_timestamp   = '0;
      beat_o.source_id         = '0;
    end
  end

endmodule

>>> sv/rtp_header_parser.sv
// the last byte loads the snapshot; the checked result then moves into the result register
// throughput: one byte per cycle unless stalled; packets may follow each other with no gap
// the input stalls only while the snapshot and the result register both hold a packet
// and the result beat is not taken
// reset: asynchronous, active low; clears the byte counter, the captured header
// and both valid flags, expected payload type returns to 96
// ----------------------------------------------------------------------------
// rtp_header_parser
// byte-wide rtp header parser with one result beat per packet
// ----------------------------------------------------------------------------
module rtp_header_parser #(
  parameter int unsigned LengthBits = rhp_pkg::LENGTH_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  rhp_stream_if.sink                      pkt_in,
  rhp_stream_if.source                    res_out,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [rhp_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [rhp_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [rhp_pkg::APB_DATA_W-1:0]  prdata,
  output logic                            pready
);

  localparam int unsigned IdxW = LengthBits + 1;

  // config register
  logic [rhp_pkg::PT_W-1:0] exp_pt_q;
  logic                     reg_sel;
  logic                     cfg_wr;

  assign reg_sel = (paddr[2] == rhp_pkg::REG_EXP_PT);
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign pready  = 1'b1;
  assign prdata  = reg_sel ? rhp_pkg::APB_DATA_W'(exp_pt_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_pt_q <= rhp_pkg::PT_RESET;
    end else if (cfg_wr && reg_sel) begin
      exp_pt_q <= pwdata[rhp_pkg::PT_W-1:0];
    end
  end

  // handshake
  logic                in_acc;
  logic                snap_vld_q;
  logic                snap_adv;
  logic                out_vld_q;
  rhp_pkg::in_beat_t   in_beat;

  assign in_beat       = pkt_in.beat;
  assign snap_adv      = snap_vld_q && (!out_vld_q || res_out.ready);
  assign pkt_in.ready  = !snap_vld_q || snap_adv;
  assign in_acc        = pkt_in.valid && pkt_in.ready;

  // header capture
  logic [IdxW-1:0] idx_q, idx_d;
  logic [7:0]      first_q, first_d;
  logic [7:0]      second_q, second_d;
  logic [15:0]     seq_q, seq_d;
  logic [31:0]     ts_q, ts_d;
  logic [31:0]     src_q, src_d;
  logic [15:0]     ew_q, ew_d;
  logic [6:0]      hdr_end;
  logic [7:0]      b;

  assign b       = in_beat.data_byte;
  assign hdr_end = 7'(rhp_pkg::HDR_BYTES) + {1'b0, first_q[3:0], 2'b00};

  always_comb begin
    first_d  = first_q;
    second_d = second_q;
    seq_d    = seq_q;
    ts_d     = ts_q;
    src_d    = src_q;
    ew_d     = ew_q;
    if (idx_q < IdxW'(rhp_pkg::HDR_BYTES)) begin
      case (idx_q[3:0])
        4'd0:    first_d         = b;
        4'd1:    second_d        = b;
        4'd2:    seq_d[15:8]     = b;
        4'd3:    seq_d[7:0]      = b;
        4'd4:    ts_d[31:24]     = b;
        4'd5:    ts_d[23:16]     = b;
        4'd6:    ts_d[15:8]      = b;
        4'd7:    ts_d[7:0]       = b;
        4'd8:    src_d[31:24]    = b;
        4'd9:    src_d[23:16]    = b;
        4'd10:   src_d[15:8]     = b;
        4'd11:   src_d[7:0]      = b;
        default: ;
      endcase
    end
    // extension word count follows the 16-bit profile field
    if (idx_q == IdxW'(hdr_end + 7'd2)) begin
      ew_d[15:8] = b;
    end else if (idx_q == IdxW'(hdr_end + 7'd3)) begin
      ew_d[7:0] = b;
    end
    // counter saturates one past the longest legal packet
    idx_d = idx_q[IdxW-1] ? idx_q : idx_q + IdxW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q    <= '0;
      first_q  <= '0;
      second_q <= '0;
      seq_q    <= '0;
      ts_q     <= '0;
      src_q    <= '0;
      ew_q     <= '0;
    end else if (in_acc) begin
      if (in_beat.last_byte) begin
        idx_q    <= '0;
        first_q  <= '0;
        second_q <= '0;
        seq_q    <= '0;
        ts_q     <= '0;
        src_q    <= '0;
        ew_q     <= '0;
      end else begin
        idx_q    <= idx_d;
        first_q  <= first_d;
        second_q <= second_d;
        seq_q    <= seq_d;
        ts_q     <= ts_d;
        src_q    <= src_d;
        ew_q     <= ew_d;
      end
    end
  end

  // snapshot stage
  rhp_pkg::snap_t  snap_q;
  logic [IdxW-1:0] snap_idx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      snap_vld_q <= 1'b0;
    end else if (in_acc && in_beat.last_byte) begin
      snap_vld_q <= 1'b1;
    end else if (snap_adv) begin
      snap_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && in_beat.last_byte) begin
      snap_q.first_hdr  <= first_d;
      snap_q.second_hdr <= second_d;
      snap_q.seq        <= seq_d;
      snap_q.tstamp     <= ts_d;
      snap_q.ssrc       <= src_d;
      snap_q.ext_wcnt   <= ew_d;
      snap_q.last_data  <= b;
      snap_idx_q        <= idx_q;
    end
  end

  // checks and result register
  rhp_pkg::out_beat_t chk_beat;
  rhp_pkg::out_beat_t out_beat_q;

  rhp_check #(
    .LengthBits (LengthBits)
  ) u_check (
    .snap_i   (snap_q),
    .idx_i    (snap_idx_q),
    .exp_pt_i (exp_pt_q),
    .beat_o   (chk_beat)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (snap_adv) begin
      out_vld_q <= 1'b1;
    end else if (res_out.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (snap_adv) begin
      out_beat_q <= chk_beat;
    end
  end

  assign res_out.valid = out_vld_q;
  assign res_out.beat  = out_beat_q;

  // checks on the datapath
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q <= IdxW'(1 << LengthBits))
    else $error("byte counter beyond saturation value");

  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && in_beat.last_byte |=> idx_q == '0 && snap_vld_q)
    else $error("last byte did not close the packet");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pkt_in.ready |-> snap_vld_q && out_vld_q && !res_out.ready)
    else $error("input stalled without a blocked result");

  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> $past(snap_vld_q))
    else $error("result beat without a snapshot");

  a_short_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_beat_q.status == rhp_pkg::ST_SHORT |->
      out_beat_q.source_id == '0 && out_beat_q.payload_size == '0)
    else $error("short packet result carries header fields");

endmodule
